### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL. They expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at any clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/mi_pkg.sv
// ---------------------------------------------------------------------------
// mi_pkg
// Shared types and constants of the modular inverse block.
// ---------------------------------------------------------------------------
package mi_pkg;

  // Modulus after reset, cut down to the data width where it is used.
  localparam logic [63:0] MOD_RESET = 64'd1000000007;

  // Commands from the top level to the core.
  typedef struct packed {
    logic start;  // load a new value and begin
    logic take;   // result moved into the output register
  } ctl_t;

  // Core status toward the top level.
  typedef struct packed {
    logic idle;   // ready for a new value
    logic done;   // result held and valid
    logic none;   // no inverse exists
  } sts_t;

endpackage

### rtl/modular_inverse_top.sv
// ---------------------------------------------------------------------------
// modular_inverse_top
// Modular inverse by binary extended gcd on one shared step unit.
// ---------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+-----------
//  input   | in_valid, in_stall, in_value            | in (stall out)
//  result  | out_valid, out_stall, out_inverse,      | out (stall in)
//          | out_no_inverse                          |
//  config  | cfg_we, cfg_wdata (modulus)             | in
//
// A transaction runs one step of the gcd sequencer per cycle (halve u, halve
// v, or subtract), then folds the coefficient into 0..modulus-1. The single
// step unit in mi_step serves both phases.
// Reset (rst_n low, synchronous) empties the core and output register and
// loads the modulus with 1000000007.
// A stalled result is held in the output register while the core already
// takes and works on the next transaction.
// ---------------------------------------------------------------------------
module modular_inverse_top #(
  parameter int DATA_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_inverse,
  output logic                  out_no_inverse,
  input  logic                  cfg_we,
  input  logic [DATA_WIDTH-1:0] cfg_wdata
);

  // Coefficients need a sign bit plus headroom for the add-then-halve steps.
  localparam int CW = DATA_WIDTH + 4;

  logic [DATA_WIDTH-1:0] modulus_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_inverse_r;
  logic                  out_no_inverse_r;
  logic [DATA_WIDTH-1:0] core_inverse;
  logic                  load;
  mi_pkg::ctl_t          ctl;
  mi_pkg::sts_t          sts;

  // Hold the modulus; the user must write it only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mi_pkg::MOD_RESET[DATA_WIDTH-1:0];
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  // Accept a new transaction only into an idle core.
  assign in_stall  = ~sts.idle;
  assign ctl.start = in_valid & sts.idle;

  // Advance a finished result once the output register is free or draining.
  assign load     = sts.done & (~out_valid_r | ~out_stall);
  assign ctl.take = load;

  mi_core #(.DW(DATA_WIDTH), .CW(CW)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .a_i       (in_value),
    .m_i       (modulus_r),
    .sts       (sts),
    .inverse_o (core_inverse)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold payload while stalled; load it only with a new result.
  always_ff @(posedge clk) begin
    if (load) begin
      out_inverse_r    <= core_inverse;
      out_no_inverse_r <= sts.none;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inverse    = out_inverse_r;
  assign out_no_inverse = out_no_inverse_r;

endmodule

### rtl/mi_step.sv
// ---------------------------------------------------------------------------
// mi_step
// One step of the binary extended gcd, or one fold of the coefficient.
// ---------------------------------------------------------------------------
module mi_step #(
  parameter int DW = 31,
  parameter int CW = 35
) (
  input  logic                 fix,
  input  logic [DW-1:0]        x,
  input  logic [DW-1:0]        y,
  input  logic [DW-1:0]        u,
  input  logic [DW-1:0]        v,
  input  logic signed [CW-1:0] ca,
  input  logic signed [CW-1:0] cb,
  input  logic signed [CW-1:0] cc,
  input  logic signed [CW-1:0] cd,
  output logic [DW-1:0]        u_o,
  output logic [DW-1:0]        v_o,
  output logic signed [CW-1:0] ca_o,
  output logic signed [CW-1:0] cb_o,
  output logic signed [CW-1:0] cc_o,
  output logic signed [CW-1:0] cd_o,
  output logic                 settled
);

  logic signed [CW-1:0] xs, ys;
  logic signed [CW-1:0] a0, b0, a1, b1, sum0, sum1;
  logic                 half_u, half_v, ge;
  logic [DW-1:0]        big, lit, diff;

  assign xs = signed'({{(CW-DW){1'b0}}, x});
  assign ys = signed'({{(CW-DW){1'b0}}, y});

  assign half_u = ~u[0];
  assign half_v = u[0] & ~v[0];
  assign ge     = (u >= v);

  // Shared magnitude subtractor: larger minus smaller.
  assign big  = ge ? u : v;
  assign lit  = ge ? v : u;
  assign diff = big - lit;

  assign settled = ~cd[CW-1] && (cd < xs);

  // Operand select for the two shared coefficient adders.
  always_comb begin
    a0 = ca;
    b0 = '0;
    a1 = cb;
    b1 = '0;
    if (fix) begin
      a1 = cd;
      b1 = cd[CW-1] ? xs : -xs;
    end else if (half_u) begin
      if (ca[0] | cb[0]) begin
        b0 = ys;
        b1 = -xs;
      end
    end else if (half_v) begin
      a0 = cc;
      a1 = cd;
      if (cc[0] | cd[0]) begin
        b0 = ys;
        b1 = -xs;
      end
    end else if (ge) begin
      b0 = -cc;
      b1 = -cd;
    end else begin
      a0 = cc;
      b0 = -ca;
      a1 = cd;
      b1 = -cb;
    end
  end

  assign sum0 = a0 + b0;
  assign sum1 = a1 + b1;

  always_comb begin
    u_o  = u;
    v_o  = v;
    ca_o = ca;
    cb_o = cb;
    cc_o = cc;
    cd_o = cd;
    if (fix) begin
      if (!settled) begin
        cd_o = sum1;
      end
    end else if (half_u) begin
      u_o  = u >> 1;
      ca_o = sum0 >>> 1;
      cb_o = sum1 >>> 1;
    end else if (half_v) begin
      v_o  = v >> 1;
      cc_o = sum0 >>> 1;
      cd_o = sum1 >>> 1;
    end else if (ge) begin
      u_o  = diff;
      ca_o = sum0;
      cb_o = sum1;
    end else begin
      v_o  = diff;
      cc_o = sum0;
      cd_o = sum1;
    end
  end

endmodule

### rtl/mi_core.sv
// ---------------------------------------------------------------------------
// mi_core
// Sequencer and state of the binary extended gcd around one step unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mi_core #(
  parameter int DW = 31,
  parameter int CW = 35
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mi_pkg::ctl_t  ctl,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] m_i,
  output mi_pkg::sts_t  sts,
  output logic [DW-1:0] inverse_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic                 none_r, none_nxt;
  logic [DW-1:0]        x_r, x_nxt, y_r, y_nxt, u_r, u_nxt, v_r, v_nxt;
  logic signed [CW-1:0] ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt, cd_r, cd_nxt;

  logic [DW-1:0]        su, sv;
  logic signed [CW-1:0] sa, sb, sc, sd;
  logic                 settled, trivial;
  logic                 fold_bad;

  mi_step #(.DW(DW), .CW(CW)) u_step (
    .fix     (state_r == S_FIX),
    .x       (x_r),
    .y       (y_r),
    .u       (u_r),
    .v       (v_r),
    .ca      (ca_r),
    .cb      (cb_r),
    .cc      (cc_r),
    .cd      (cd_r),
    .u_o     (su),
    .v_o     (sv),
    .ca_o    (sa),
    .cb_o    (sb),
    .cc_o    (sc),
    .cd_o    (sd),
    .settled (settled)
  );

  // Modulus below two, zero value, or both even: no inverse without iterating.
  assign trivial = (m_i[DW-1:1] == '0) || (a_i == '0) || (~m_i[0] & ~a_i[0]);

  always_comb begin
    state_nxt = state_r;
    none_nxt  = none_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    cc_nxt    = cc_r;
    cd_nxt    = cd_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          x_nxt     = m_i;
          y_nxt     = a_i;
          u_nxt     = m_i;
          v_nxt     = a_i;
          ca_nxt    = CW'(1);
          cb_nxt    = '0;
          cc_nxt    = '0;
          cd_nxt    = CW'(1);
          none_nxt  = trivial;
          state_nxt = trivial ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (u_r == '0) begin
          // v holds the gcd; only a gcd of one has an inverse
          none_nxt  = (v_r != DW'(1));
          state_nxt = (v_r != DW'(1)) ? S_DONE : S_FIX;
        end else begin
          u_nxt  = su;
          v_nxt  = sv;
          ca_nxt = sa;
          cb_nxt = sb;
          cc_nxt = sc;
          cd_nxt = sd;
        end
      end
      S_FIX: begin
        cd_nxt = sd;
        if (settled) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    none_r <= none_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    cc_r   <= cc_nxt;
    cd_r   <= cd_nxt;
  end

  assign sts.idle  = (state_r == S_IDLE);
  assign sts.done  = (state_r == S_DONE);
  assign sts.none  = none_r;
  assign inverse_o = none_r ? '0 : cd_r[DW-1:0];

  // Coefficient outside 0..modulus-1.
  assign fold_bad = cd_r[CW-1] || (cd_r[CW-2:0] >= (CW-1)'(x_r));

  `ASSERT_CLK(a_start_idle, ctl.start |-> sts.idle, "start while core busy")
  `ASSERT_CLK(a_take_done, ctl.take |-> sts.done, "take without a result")
  `ASSERT_CLK(a_start_leaves, ctl.start |=> !sts.idle, "core stayed idle after start")
  `ASSERT_NEVER(a_v_zero, (state_r == S_RUN) && (v_r == '0), "v reached zero in run")
  `ASSERT_NEVER(a_fold_range, sts.done && !none_r && fold_bad, "folded inverse out of range")

endmodule
